FILE: hdl/jls_pkg.sv
// jls_pkg: shared types, codes and fixed-point helpers for the jacobi solver
// no dependencies
`timescale 1ns / 1ps
package jls_pkg;

	localparam int DW = 32;
	localparam int QW = 48;
	localparam int ACCW = 52;
	localparam int EMIT_MAX = 16;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_TOL = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [4:0] ORDER_RST = 5'd16;
	localparam logic [15:0] TOL_RST = 16'd66;
	localparam logic [15:0] LIMIT_RST = 16'd50000;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] ERR_SAT = 32'hFFFF_FFFF;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIAG_RD,
		ST_DIAG_CHK,
		ST_SING,
		ST_N_DRD,
		ST_N_DLAT,
		ST_N_ERD,
		ST_N_EDIV,
		ST_N_EWAIT,
		ST_INIT,
		ST_CHECK,
		ST_MAC,
		ST_DRAIN,
		ST_ERR,
		ST_ERR_FIN,
		ST_ERR_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear;
		logic init;
		logic copy;
		logic b_shift;
		logic p_shift;
		logic n_shift;
	} cell_ctrl_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		logic [31:0] r;
		r = v[31] ? (~v + 32'd1) : v;
		return r;
	endfunction

	function automatic logic [31:0] sat_quot(input logic [QW-1:0] q, input logic neg);
		logic [31:0] r;
		if (!neg) begin
			r = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end else begin
			r = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_acc(input logic [ACCW:0] v);
		logic [31:0] r;
		if (&v[ACCW:31] || ~|v[ACCW:31]) begin
			r = v[31:0];
		end else begin
			r = v[ACCW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

FILE: hdl/jls_div.sv
// jls_div: restoring divider, one quotient bit per cycle
// depends on jls_pkg
`timescale 1ns / 1ps
module jls_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [jls_pkg::QW-1:0] dividend,
	input  logic [jls_pkg::DW-1:0] divisor,
	output logic                   done,
	output logic [jls_pkg::QW-1:0] quotient
);
	import jls_pkg::*;

	logic          run_q;
	logic [5:0]    cnt_q;
	logic [DW:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          fit;

	always_comb begin
		trial = {rem_q[DW-1:0], quo_q[QW-1]};
		fit = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(QW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fit ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[QW-2:0], fit};
		end
	end

	assign quotient = quo_q;

endmodule

FILE: hdl/jls_cell.sv
// jls_cell: one solution entry, holding b, previous x and next x
// depends on jls_pkg; chained by the top level
`timescale 1ns / 1ps
module jls_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jls_pkg::cell_ctrl_t    ctrl,
	input  logic                   tail,
	input  logic [jls_pkg::DW-1:0] b_nb,
	input  logic [jls_pkg::DW-1:0] p_nb,
	input  logic [jls_pkg::DW-1:0] n_nb,
	input  logic [jls_pkg::DW-1:0] b_feed,
	input  logic [jls_pkg::DW-1:0] p_feed,
	input  logic [jls_pkg::DW-1:0] n_feed,
	output logic [jls_pkg::DW-1:0] b_val,
	output logic [jls_pkg::DW-1:0] p_val,
	output logic [jls_pkg::DW-1:0] n_val
);
	import jls_pkg::*;

	logic [DW-1:0] b_q, p_q, n_q;

	always_ff @(posedge clk) begin
		if (ctrl.b_shift) begin
			b_q <= tail ? b_feed : b_nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
			n_q <= '0;
		end else if (ctrl.clear) begin
			p_q <= '0;
			n_q <= '0;
		end else if (ctrl.init) begin
			p_q <= b_q;
			n_q <= b_q;
		end else if (ctrl.copy) begin
			p_q <= n_q;
		end else begin
			if (ctrl.p_shift) begin
				p_q <= tail ? p_feed : p_nb;
			end
			if (ctrl.n_shift) begin
				n_q <= tail ? n_feed : n_nb;
			end
		end
	end

	assign b_val = b_q;
	assign p_val = p_q;
	assign n_val = n_q;

endmodule

FILE: hdl/jacobi_linear_solver.sv
// jacobi_linear_solver: top level, control, coefficient memories and cell chain
// depends on jls_pkg, jls_div, jls_cell
//
// usage: requests on the input channel load A (op 0, row, col) and b (op 1, row),
// one per cycle while idle; op 2 starts a solve of the order set in the order
// register. registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while idle, as the block does not enforce it. a solve
// checks the n diagonals, then normalizes the system through a serial divider:
// n*n divisions (off-diagonal entries and b). it then runs sweeps. each sweep
// streams n*n products through a row of n cells that rotate x past one
// multiply-accumulate unit, finds the largest change and the largest magnitude,
// and divides the one by the other for the relative error.
// results, n of them, come out on the output channel; the block holds
// each one while out_ready is low and takes no request until the last is taken.
// reset clears control and the x cells, sets order 16, tolerance 66, limit 50000;
// the A and b memories are not cleared.
`timescale 1ns / 1ps
module jacobi_linear_solver #(
	parameter int MAX_ORDER = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  row,
	input  logic [3:0]  col,
	input  logic signed [31:0] element_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  index,
	output logic signed [31:0] solution_value,
	output logic [31:0] relative_error,
	output logic [15:0] sweeps,
	output logic        converged,
	output logic        singular,
	output logic        last,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import jls_pkg::*;

	localparam int NC = (MAX_ORDER < EMIT_MAX) ? MAX_ORDER : EMIT_MAX;
	localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
	localparam int RW = $clog2(MAX_ORDER);

	function automatic logic [AW-1:0] addr_of(input logic [3:0] r, input logic [3:0] c);
		return AW'(32'(r) * MAX_ORDER + 32'(c));
	endfunction

	state_t state_q, state_d;
	logic [4:0]  order_q;
	logic [15:0] tol_q, limit_q;
	logic [4:0]  n_w, nm1;
	logic [3:0]  i_q, j_q, out_idx_q;
	logic        nb_q, neg_q, sing_q;
	logic [31:0] err_q, d_q, md_q, mm_q;
	logic [15:0] sweeps_q;

	logic [31:0] coeff_mem [MAX_ORDER*MAX_ORDER];
	logic [31:0] norm_mem [MAX_ORDER*MAX_ORDER];
	logic [31:0] rhs_mem [MAX_ORDER];
	logic [31:0] coeff_rd_q, norm_rd_q, rhs_rd_q;
	logic [3:0]  ccol;
	logic        load_a, load_b, start_req;
	logic        norm_we;
	logic [31:0] norm_wd;

	logic          div_start, div_done;
	logic [QW-1:0] div_dvd, div_q;
	logic [DW-1:0] div_dvs;
	logic [31:0]   v_sel, norm_res;

	logic          v_s1, first_s1, last_s1, fin_s1;
	logic [31:0]   x_s1;
	logic          v_s2, first_s2, last_s2, fin_s2;
	logic signed [63:0] prod_s2;
	logic [ACCW-1:0] acc_q, sum_w;
	logic [31:0]   x_new;
	logic          row_done;

	cell_ctrl_t  cc;
	logic [31:0] b_feed, p_feed, n_feed;
	logic [31:0] b_v [NC];
	logic [31:0] p_v [NC];
	logic [31:0] n_v [NC];
	logic [32:0] diff33;
	logic [31:0] dv, mv;
	logic        mac_end, row_end;

	always_comb begin
		if (order_q == 5'd0) begin
			n_w = 5'd1;
		end else if (32'(order_q) > NC) begin
			n_w = 5'(NC);
		end else begin
			n_w = order_q;
		end
		nm1 = n_w - 5'd1;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RST;
			tol_q <= TOL_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ORDER: order_q <= cfg_data[4:0];
				REG_TOL:   tol_q <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign start_req = in_valid && in_ready && (op == OP_START);
	assign load_a = in_valid && in_ready && (op == OP_LOAD_A)
		&& (32'(row) < MAX_ORDER) && (32'(col) < MAX_ORDER);
	assign load_b = in_valid && in_ready && (op == OP_LOAD_B) && (32'(row) < MAX_ORDER);

	// memories
	assign ccol = ((state_q == ST_DIAG_RD) || (state_q == ST_N_DRD)) ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (load_a) begin
			coeff_mem[addr_of(row, col)] <= element_value;
		end
		coeff_rd_q <= coeff_mem[addr_of(i_q, ccol)];
	end

	always_ff @(posedge clk) begin
		if (norm_we) begin
			norm_mem[addr_of(i_q, j_q)] <= norm_wd;
		end
		norm_rd_q <= norm_mem[addr_of(i_q, j_q)];
	end

	always_ff @(posedge clk) begin
		if (load_b) begin
			rhs_mem[RW'(row)] <= element_value;
		end
		rhs_rd_q <= rhs_mem[RW'(i_q)];
	end

	// divider
	assign v_sel = nb_q ? rhs_rd_q : coeff_rd_q;
	assign norm_res = sat_quot(div_q, neg_q);

	always_comb begin
		if (state_q == ST_ERR_FIN) begin
			div_dvd = {md_q, 16'h0000};
			div_dvs = mm_q;
		end else begin
			div_dvd = {mag32(v_sel), 16'h0000};
			div_dvs = mag32(d_q);
		end
	end

	jls_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	// multiply-accumulate datapath
	assign row_done = v_s2 && last_s2;
	assign sum_w = (first_s2 ? '0 : acc_q) + {{(ACCW-48){prod_s2[63]}}, prod_s2[63:16]};
	assign x_new = sat_acc({{(ACCW-31){b_v[0][31]}}, b_v[0]} - {sum_w[ACCW-1], sum_w});
	assign mac_end = (i_q == nm1[3:0]) && (j_q == nm1[3:0]);
	assign row_end = (j_q == nm1[3:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (j_q == 4'd0);
		last_s1 <= row_end;
		fin_s1 <= mac_end;
		x_s1 <= p_v[0];
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		fin_s2 <= fin_s1;
		prod_s2 <= $signed(norm_rd_q) * $signed(x_s1);
		if (v_s2) begin
			acc_q <= sum_w;
		end
	end

	// error scan
	assign diff33 = {n_v[0][31], n_v[0]} - {p_v[0][31], p_v[0]};
	assign dv = diff33[32] ? (~diff33[31:0] + 32'd1) : diff33[31:0];
	assign mv = mag32(n_v[0]);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cc = '0;
		norm_we = 1'b0;
		norm_wd = norm_res;
		div_start = 1'b0;
		b_feed = b_v[0];
		n_feed = n_v[0];
		p_feed = p_v[0];
		if (row_done) begin
			cc.n_shift = 1'b1;
			cc.b_shift = 1'b1;
			n_feed = x_new;
		end
		case (state_q)
			ST_IDLE: begin
				if (start_req) begin
					state_d = ST_DIAG_RD;
				end
			end
			ST_DIAG_RD: state_d = ST_DIAG_CHK;
			ST_DIAG_CHK: begin
				if (coeff_rd_q == '0) begin
					state_d = ST_SING;
				end else if (i_q == nm1[3:0]) begin
					state_d = ST_N_DRD;
				end else begin
					state_d = ST_DIAG_RD;
				end
			end
			ST_SING: begin
				cc.clear = 1'b1;
				state_d = ST_OUT;
			end
			ST_N_DRD: state_d = ST_N_DLAT;
			ST_N_DLAT: state_d = ST_N_ERD;
			ST_N_ERD: begin
				if (!nb_q && (j_q == i_q)) begin
					norm_we = 1'b1;
					norm_wd = '0;
				end else begin
					state_d = ST_N_EDIV;
				end
			end
			ST_N_EDIV: begin
				div_start = 1'b1;
				state_d = ST_N_EWAIT;
			end
			ST_N_EWAIT: begin
				if (div_done) begin
					if (nb_q) begin
						cc.b_shift = 1'b1;
						b_feed = norm_res;
						state_d = (i_q == nm1[3:0]) ? ST_INIT : ST_N_DRD;
					end else begin
						norm_we = 1'b1;
						state_d = ST_N_ERD;
					end
				end
			end
			ST_INIT: begin
				cc.init = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if ((err_q > 32'(tol_q)) && (sweeps_q < limit_q)) begin
					state_d = ST_MAC;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_MAC: begin
				cc.p_shift = 1'b1;
				if (mac_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (row_done && fin_s2) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR: begin
				cc.p_shift = 1'b1;
				cc.n_shift = 1'b1;
				if (i_q == nm1[3:0]) begin
					state_d = ST_ERR_FIN;
				end
			end
			ST_ERR_FIN: begin
				cc.copy = 1'b1;
				if (mm_q == '0) begin
					state_d = ST_CHECK;
				end else begin
					div_start = 1'b1;
					state_d = ST_ERR_WAIT;
				end
			end
			ST_ERR_WAIT: begin
				if (div_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					cc.n_shift = 1'b1;
					if (out_idx_q == nm1[3:0]) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			nb_q <= 1'b0;
			sing_q <= 1'b0;
			err_q <= '0;
			sweeps_q <= '0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					sing_q <= 1'b0;
					out_idx_q <= '0;
				end
				ST_DIAG_CHK: begin
					if (coeff_rd_q == '0) begin
						sing_q <= 1'b1;
					end
					i_q <= (i_q == nm1[3:0]) ? 4'd0 : i_q + 4'd1;
				end
				ST_SING: begin
					err_q <= ERR_SAT;
					sweeps_q <= '0;
				end
				ST_N_DLAT: begin
					j_q <= '0;
					nb_q <= 1'b0;
				end
				ST_N_ERD: begin
					if (!nb_q && (j_q == i_q)) begin
						if (row_end) begin
							nb_q <= 1'b1;
						end else begin
							j_q <= j_q + 4'd1;
						end
					end
				end
				ST_N_EWAIT: begin
					if (div_done) begin
						if (nb_q) begin
							i_q <= i_q + 4'd1;
						end else if (row_end) begin
							nb_q <= 1'b1;
						end else begin
							j_q <= j_q + 4'd1;
						end
					end
				end
				ST_INIT: begin
					err_q <= ONE_Q16;
					sweeps_q <= '0;
				end
				ST_CHECK: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_MAC: begin
					if (row_end) begin
						j_q <= '0;
						i_q <= mac_end ? 4'd0 : i_q + 4'd1;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_DRAIN: i_q <= '0;
				ST_ERR: i_q <= i_q + 4'd1;
				ST_ERR_FIN: begin
					sweeps_q <= sweeps_q + 16'd1;
					if (mm_q == '0) begin
						err_q <= (md_q == '0) ? 32'd0 : ERR_SAT;
					end
				end
				ST_ERR_WAIT: begin
					if (div_done) begin
						err_q <= (div_q[QW-1:32] != '0) ? ERR_SAT : div_q[31:0];
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_idx_q <= out_idx_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_N_DLAT) begin
			d_q <= coeff_rd_q;
		end
		if (state_q == ST_N_EDIV) begin
			neg_q <= v_sel[31] ^ d_q[31];
		end
		if (state_q == ST_DRAIN) begin
			md_q <= '0;
			mm_q <= '0;
		end else if (state_q == ST_ERR) begin
			if (dv > md_q) begin
				md_q <= dv;
			end
			if (mv > mm_q) begin
				mm_q <= mv;
			end
		end
	end

	// cell chain
	for (genvar k = 0; k < NC; k++) begin : g_cell
		logic [31:0] b_nb, p_nb, n_nb;
		if (k == NC - 1) begin : g_end
			assign b_nb = b_feed;
			assign p_nb = p_feed;
			assign n_nb = n_feed;
		end else begin : g_mid
			assign b_nb = b_v[k+1];
			assign p_nb = p_v[k+1];
			assign n_nb = n_v[k+1];
		end
		jls_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cc),
			.tail   (nm1 == 5'(k)),
			.b_nb   (b_nb),
			.p_nb   (p_nb),
			.n_nb   (n_nb),
			.b_feed (b_feed),
			.p_feed (p_feed),
			.n_feed (n_feed),
			.b_val  (b_v[k]),
			.p_val  (p_v[k]),
			.n_val  (n_v[k])
		);
	end

	// result
	assign out_valid = (state_q == ST_OUT);
	assign index = out_idx_q;
	assign solution_value = sing_q ? '0 : n_v[0];
	assign relative_error = err_q;
	assign sweeps = sweeps_q;
	assign converged = !sing_q && (err_q <= 32'(tol_q));
	assign singular = sing_q;
	assign last = (out_idx_q == nm1[3:0]);

endmodule

FILE: hdl/jls_checker.sv
// jls_checker: port-level checks on the solver result stream
// depends on jacobi_linear_solver ports; bound to the top level below
`timescale 1ns / 1ps
module jls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  index,
	input logic [31:0] solution_value,
	input logic [31:0] relative_error,
	input logic        converged,
	input logic        singular,
	input logic        last
);

	// no new request while results are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken during result output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(index) && $stable(solution_value))
		else $error("stalled result changed");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> solution_value == 32'd0 && !converged
			&& relative_error == 32'hFFFF_FFFF) else $error("bad singular result");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && index == $past(index) + 4'd1)
		else $error("result index skipped");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid) else $error("result after last");

endmodule

bind jacobi_linear_solver jls_checker u_jls_checker (.*);

FILE: tb/jls_solution_checker.sv
// jls_solution_checker: watches the request, result and register ports of the jacobi solver,
// predicts every solution entry in fixed point and compares it field by field
// depends on jls_pkg
`timescale 1ns / 1ps
module jls_solution_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  row,
	input  logic [3:0]  col,
	input  logic signed [31:0] element_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  index,
	input  logic signed [31:0] solution_value,
	input  logic [31:0] relative_error,
	input  logic [15:0] sweeps,
	input  logic        converged,
	input  logic        singular,
	input  logic        last,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import jls_pkg::*;

	typedef struct {
		logic [3:0]  index;
		logic [31:0] value;
		logic [31:0] rel_err;
		logic [15:0] sweeps;
		logic        converged;
		logic        singular;
		logic        last;
	} solution_t;

	solution_t solution_q[$];
	logic signed [31:0] coeff_mem[16][16];
	logic signed [31:0] rhs_mem[16];
	logic [4:0]  order_reg;
	logic [15:0] tol_reg;
	logic [15:0] limit_reg;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic int sat_word(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return int'(v);
	endfunction

	function automatic int normalize(input logic signed [31:0] v, input logic signed [31:0] d);
		longint num;
		num = longint'(v) * 65536;
		return sat_word(num / longint'(d));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic solve_system();
		longint a[16][16];
		longint bn[16];
		longint px[16];
		longint nx[16];
		longint err, md, mm, acc, dv, mv;
		int n, cnt;
		logic sing;
		solution_t s;
		n = (order_reg == 0) ? 1 : ((order_reg > 16) ? 16 : int'(order_reg));
		sing = 0;
		for (int i = 0; i < n; i++) begin
			if (!sing) begin
				if (coeff_mem[i][i] == 0) begin
					sing = 1;
				end else begin
					for (int j = 0; j < n; j++)
						a[i][j] = (i == j) ? 0 : normalize(coeff_mem[i][j], coeff_mem[i][i]);
					bn[i] = normalize(rhs_mem[i], coeff_mem[i][i]);
				end
			end
		end
		err = 65536;
		cnt = 0;
		if (sing) begin
			err = 64'hFFFF_FFFF;
		end else begin
			for (int i = 0; i < n; i++)
				nx[i] = bn[i];
			while (err > tol_reg && cnt < limit_reg) begin
				for (int i = 0; i < n; i++)
					px[i] = nx[i];
				for (int i = 0; i < n; i++) begin
					acc = 0;
					for (int j = 0; j < n; j++)
						acc += (a[i][j] * px[j]) >>> 16;
					nx[i] = sat_word(bn[i] - acc);
				end
				md = 0;
				mm = 0;
				for (int i = 0; i < n; i++) begin
					dv = nx[i] - px[i];
					if (dv < 0)
						dv = -dv;
					mv = (nx[i] < 0) ? -nx[i] : nx[i];
					if (dv > md)
						md = dv;
					if (mv > mm)
						mm = mv;
				end
				if (mm == 0) begin
					err = (md == 0) ? 0 : 64'hFFFF_FFFF;
				end else begin
					err = (md <<< 16) / mm;
					if (err > 64'hFFFF_FFFF)
						err = 64'hFFFF_FFFF;
				end
				cnt++;
			end
		end
		for (int i = 0; i < n; i++) begin
			s.index = i[3:0];
			s.value = sing ? 32'd0 : nx[i][31:0];
			s.rel_err = err[31:0];
			s.sweeps = cnt[15:0];
			s.converged = !sing && (err <= tol_reg);
			s.singular = sing;
			s.last = (i == n - 1);
			solution_q.push_back(s);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		solution_t e;
		if (!arst_n) begin
			order_reg = ORDER_RST;
			tol_reg = TOL_RST;
			limit_reg = LIMIT_RST;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ORDER: order_reg = cfg_data[4:0];
					REG_TOL: tol_reg = cfg_data;
					REG_LIMIT: limit_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (op)
					OP_LOAD_A: coeff_mem[row][col] = element_value;
					OP_LOAD_B: rhs_mem[row] = element_value;
					OP_START: solve_system();
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (solution_q.size() == 0) begin
					$display("%0t unexpected result index %0d", $realtime, index);
					fail_count++;
				end else begin
					e = solution_q.pop_front();
					if (index !== e.index)
						report_mismatch("index", index, e.index);
					if (solution_value !== e.value)
						report_mismatch("solution_value", solution_value, e.value);
					if (relative_error !== e.rel_err)
						report_mismatch("relative_error", relative_error, e.rel_err);
					if (sweeps !== e.sweeps)
						report_mismatch("sweeps", sweeps, e.sweeps);
					if (converged !== e.converged)
						report_mismatch("converged", converged, e.converged);
					if (singular !== e.singular)
						report_mismatch("singular", singular, e.singular);
					if (last !== e.last)
						report_mismatch("last", last, e.last);
				end
			end
			pending = solution_q.size();
		end
	end

endmodule

FILE: tb/tb_jacobi_linear_solver.sv
// tb_jacobi_linear_solver: stimulus and verdict for the jacobi solver
// depends on jls_pkg, jacobi_linear_solver and jls_solution_checker
`timescale 1ns / 1ps
module tb_jacobi_linear_solver;
	import jls_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  op = OP_LOAD_A;
	logic [3:0]  row = 0;
	logic [3:0]  col = 0;
	logic signed [31:0] element_value = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [3:0]  index;
	logic signed [31:0] solution_value;
	logic [31:0] relative_error;
	logic [15:0] sweeps;
	logic        converged;
	logic        singular;
	logic        last;
	logic        cfg_write = 0;
	logic [1:0]  cfg_index = REG_ORDER;
	logic [15:0] cfg_data = 0;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          sent_items = 0;

	jacobi_linear_solver i_dut (.*);

	jls_solution_checker i_checker (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_req(input logic [1:0] o, input logic [3:0] r, input logic [3:0] c,
			input logic [31:0] v);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		row <= r;
		col <= c;
		element_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (o != OP_UNUSED)
			sent_items++;
	endtask

	task automatic settle();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(input logic [4:0] n, input logic [15:0] tol,
			input logic [15:0] lim);
		cfg_write <= 1;
		cfg_index <= REG_ORDER;
		cfg_data <= {11'd0, n};
		@(posedge clk);
		cfg_index <= REG_TOL;
		cfg_data <= tol;
		@(posedge clk);
		cfg_index <= REG_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_write <= 0;
	endtask

	function automatic logic [31:0] diag_value();
		logic [31:0] m;
		m = (8 + $urandom_range(0, 32)) << 16;
		m = m + $urandom_range(0, 65535);
		return $urandom_range(1) ? m : -m;
	endfunction

	function automatic logic [31:0] small_value();
		return $urandom_range(0, 65535) - 32768;
	endfunction

	initial begin
		int n, lim, tol, round;
		logic wild;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// well conditioned full system
		for (int r = 0; r < 16; r++) begin
			for (int c = 0; c < 16; c++)
				send_req(OP_LOAD_A, r, c, (r == c) ? diag_value() : small_value());
			send_req(OP_LOAD_B, r, 0, $urandom);
		end
		settle();

		set_config(16, 66, 60);
		send_req(OP_START, 0, 0, 0);
		send_req(OP_START, 0, 0, 0);
		settle();
		set_config(1, 0, 1);
		send_req(OP_START, 0, 0, 0);
		settle();
		set_config(2, 65535, 65535);
		send_req(OP_START, 0, 0, 0);
		settle();

		// zero diagonal
		set_config(3, 66, 20);
		send_req(OP_LOAD_A, 1, 1, 0);
		send_req(OP_START, 0, 0, 0);
		send_req(OP_LOAD_A, 1, 1, diag_value());
		settle();

		// zero right-hand side gives 0/0
		set_config(1, 0, 10);
		send_req(OP_LOAD_B, 0, 0, 0);
		send_req(OP_START, 0, 0, 0);
		settle();

		// extreme values saturate
		set_config(2, 0, 3);
		send_req(OP_LOAD_A, 0, 0, 32'h0000_0001);
		send_req(OP_LOAD_A, 0, 1, 32'h8000_0000);
		send_req(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF);
		send_req(OP_LOAD_A, 1, 1, 32'hFFFF_FFFF);
		send_req(OP_LOAD_A, 1, 0, 32'h7FFF_FFFF);
		send_req(OP_LOAD_B, 1, 0, 32'h8000_0000);
		send_req(OP_UNUSED, 4'hF, 4'hF, 32'hFFFF_FFFF);
		send_req(OP_START, 0, 0, 0);
		settle();

		// order outside its range
		set_config(0, 66, 5);
		send_req(OP_START, 0, 0, 0);
		settle();
		set_config(31, 65535, 2);
		send_req(OP_START, 0, 0, 0);
		settle();

		sent_items = 0;
		round = 0;
		while (sent_items < 120) begin
			case (round % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			round++;
			n = ($urandom_range(7) == 0) ? 16 : $urandom_range(1, 4);
			wild = ($urandom_range(3) == 0);
			case ($urandom_range(3))
				0: tol = 0;
				1: tol = 65535;
				2: tol = 66;
				default: tol = $urandom_range(0, 65535);
			endcase
			lim = (n == 16) ? $urandom_range(1, 8) : $urandom_range(1, 40);
			set_config(n, tol, lim);
			for (int r = 0; r < n; r++) begin
				for (int c = 0; c < n; c++)
					if (n <= 4 || r == c)
						send_req(OP_LOAD_A, r, c, wild ? $urandom :
							((r == c) ? diag_value() : small_value()));
				send_req(OP_LOAD_B, r, 0, $urandom);
			end
			if ($urandom_range(5) == 0)
				send_req(OP_LOAD_A, $urandom_range(0, n - 1) * 17 % 16 == 0 ? 0 : 0, 0, 0);
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(1))
					send_req(OP_UNUSED, $urandom, $urandom, $urandom);
				else
					send_req($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B, $urandom, $urandom,
						$urandom);
			end
			send_req(OP_START, $urandom, $urandom, $urandom);
			if ($urandom_range(4) == 0)
				send_req(OP_START, 0, 0, 0);
			settle();
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
